### hw/rtl/mlfq_pkg.sv
// Shared types and constants for the feedback queue scheduler.
`default_nettype none
package mlfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LEVELS  = 3;
  localparam int TIME_WIDTH  = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int ID_W        = 8;
  localparam int REM_W       = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int PRIO_W      = 2;
  localparam int OUT_LVL_W   = 2;

  typedef struct packed {
    logic                  valid;
    logic [LVL_W-1:0]      lvl;
    logic [IDX_W-1:0]      seq;
    logic [ID_W-1:0]       id;
    logic [REM_W-1:0]      rem;
    logic [TIME_WIDTH-1:0] stamp;
  } mlfq_entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_BOOST,
    OP_AGE,
    OP_SORT,
    OP_SHIFT
  } mlfq_op_t;

  typedef struct packed {
    mlfq_op_t              op;
    logic                  phase;
    logic [IDX_W-1:0]      wr_idx;
    mlfq_entry_t           wr_ent;
    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] thr;
  } mlfq_ctl_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED,
    ST_FULL,
    ST_SELECTED,
    ST_EMPTY
  } mlfq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOOST,
    S_AGE,
    S_SORT,
    S_POP
  } mlfq_state_t;

  typedef enum logic [2:0] {
    REG_AGING_THR,
    REG_BOOST_INT,
    REG_QUANTUM0,
    REG_QUANTUM1,
    REG_QUANTUM2
  } mlfq_reg_t;

endpackage
`default_nettype wire

### hw/rtl/mlfq_scheduler_with_aging.sv
// Top level: command sequencer, configuration registers and the cell chain.
// Enqueue: result registered in the cycle after accept; then busy while the sort passes run.
// Full enqueue: result registered in the cycle after accept; does not go busy.
// Select: boost check, aging step, odd-even sort passes over the cell chain, then pop;
// the result is registered from the pop state; next command accepted when the result appears.
// Synchronous active-low reset empties all levels and loads register defaults.
`default_nettype none
module mlfq_scheduler_with_aging (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_cmd,
  input  wire logic [mlfq_pkg::ID_W-1:0]        in_process_id,
  input  wire logic [mlfq_pkg::PRIO_W-1:0]      in_priority_req,
  input  wire logic [mlfq_pkg::REM_W-1:0]       in_remaining,
  input  wire logic [mlfq_pkg::TIME_WIDTH-1:0]  in_now,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [mlfq_pkg::ID_W-1:0]             out_chosen_id,
  output logic [mlfq_pkg::OUT_LVL_W-1:0]        out_chosen_level,
  output logic [mlfq_pkg::REM_W-1:0]            out_time_slice,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mlfq_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [mlfq_pkg::DATA_W-1:0]      pwdata,
  output logic [mlfq_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import mlfq_pkg::*;

  localparam logic [IDX_W-1:0] SORT_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  logic [DATA_W-1:0] aging_thr_r, boost_int_r, quantum0_r, quantum1_r, quantum2_r;
  logic              cfg_wr;
  mlfq_reg_t         cfg_idx;

  mlfq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  sort_cnt_r, sort_cnt_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [TIME_WIDTH-1:0] boost_mark_r, boost_mark_nxt;
  logic              sel_r, sel_nxt;

  logic              out_valid_r, out_valid_nxt;
  mlfq_status_t      status_r, status_nxt;
  logic [ID_W-1:0]   chosen_id_r, chosen_id_nxt;
  logic [OUT_LVL_W-1:0] chosen_lvl_r, chosen_lvl_nxt;
  logic [REM_W-1:0]  slice_r, slice_nxt;

  mlfq_ctl_t         ctl;
  mlfq_entry_t       ent [QUEUE_DEPTH];
  mlfq_entry_t       blank;
  mlfq_entry_t       head;
  logic [REM_W-1:0]  quantum;
  logic [LVL_W-1:0]  req_lvl;
  logic              accept;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = mlfq_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_thr_r <= DATA_W'(20);
      boost_int_r <= DATA_W'(80);
      quantum0_r  <= DATA_W'(3);
      quantum1_r  <= DATA_W'(23);
      quantum2_r  <= DATA_W'(65);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AGING_THR: aging_thr_r <= pwdata;
        REG_BOOST_INT: boost_int_r <= pwdata;
        REG_QUANTUM0:  quantum0_r  <= pwdata;
        REG_QUANTUM1:  quantum1_r  <= pwdata;
        REG_QUANTUM2:  quantum2_r  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_AGING_THR: prdata = aging_thr_r;
      REG_BOOST_INT: prdata = boost_int_r;
      REG_QUANTUM0:  prdata = quantum0_r;
      REG_QUANTUM1:  prdata = quantum1_r;
      REG_QUANTUM2:  prdata = quantum2_r;
      default:       prdata = '0;
    endcase
  end

  assign blank   = '0;
  assign head    = ent[0];
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign req_lvl = (in_priority_req >= PRIO_W'(NUM_LEVELS)) ?
                   LVL_W'(NUM_LEVELS - 1) : LVL_W'(in_priority_req);

  always_comb begin
    if (head.lvl == '0) begin
      quantum = quantum0_r;
    end else if (head.lvl == LVL_W'(1)) begin
      quantum = quantum1_r;
    end else begin
      quantum = quantum2_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sort_cnt_nxt   = sort_cnt_r;
    now_nxt        = now_r;
    boost_mark_nxt = boost_mark_r;
    sel_nxt        = sel_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = ST_ENQUEUED;
    chosen_id_nxt  = '0;
    chosen_lvl_nxt = '0;
    slice_nxt      = '0;

    ctl              = '0;
    ctl.op           = OP_HOLD;
    ctl.phase        = sort_cnt_r[0];
    ctl.wr_idx       = count_r[IDX_W-1:0];
    ctl.wr_ent.valid = 1'b1;
    ctl.wr_ent.lvl   = req_lvl;
    ctl.wr_ent.seq   = count_r[IDX_W-1:0];
    ctl.wr_ent.id    = in_process_id;
    ctl.wr_ent.rem   = in_remaining;
    ctl.wr_ent.stamp = in_now;
    ctl.now          = now_r;
    ctl.thr          = aging_thr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          sel_nxt = in_cmd;
          if (in_cmd) begin
            now_nxt   = in_now;
            state_nxt = S_BOOST;
          end else if (count_r == FULL_CNT) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_FULL;
          end else begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_ENQUEUED;
            ctl.op        = OP_WRITE;
            count_nxt     = count_r + CNT_W'(1);
            sort_cnt_nxt  = '0;
            state_nxt     = S_SORT;
          end
        end
      end
      S_BOOST: begin
        if ((now_r - boost_mark_r) >= boost_int_r) begin
          ctl.op         = OP_BOOST;
          boost_mark_nxt = now_r;
        end
        state_nxt = S_AGE;
      end
      S_AGE: begin
        ctl.op       = OP_AGE;
        sort_cnt_nxt = '0;
        state_nxt    = S_SORT;
      end
      S_SORT: begin
        ctl.op       = OP_SORT;
        sort_cnt_nxt = sort_cnt_r + IDX_W'(1);
        if (sort_cnt_r == SORT_LAST) begin
          state_nxt = sel_r ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (count_r != '0) begin
          ctl.op         = OP_SHIFT;
          count_nxt      = count_r - CNT_W'(1);
          status_nxt     = ST_SELECTED;
          chosen_id_nxt  = head.id;
          chosen_lvl_nxt = OUT_LVL_W'(head.lvl);
          slice_nxt      = (head.rem < quantum) ? head.rem : quantum;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      sort_cnt_r   <= '0;
      boost_mark_r <= '0;
      sel_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      sort_cnt_r   <= sort_cnt_nxt;
      boost_mark_r <= boost_mark_nxt;
      sel_r        <= sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    status_r     <= status_nxt;
    chosen_id_r  <= chosen_id_nxt;
    chosen_lvl_r <= chosen_lvl_nxt;
    slice_r      <= slice_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_chosen_id    = chosen_id_r;
  assign out_chosen_level = chosen_lvl_r;
  assign out_time_slice   = slice_r;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    mlfq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (IDX_W'(g)),
      .ctl     (ctl),
      .left_i  ((g == 0) ? blank : ent[(g == 0) ? 0 : g - 1]),
      .right_i ((g == QUEUE_DEPTH - 1) ? blank : ent[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
      .ent_o   (ent[g])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_cmd && count_r == FULL_CNT) |=> (out_valid && out_status == ST_FULL))
    else $error("full enqueue not refused");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (out_valid && (out_status == ST_SELECTED || out_status == ST_EMPTY)))
    else $error("select gave no result");

endmodule
`default_nettype wire

### hw/rtl/mlfq_cell.sv
// One slot of the ordered entry chain: write, retag, boost, age, compare-swap and shift.
`default_nettype none
module mlfq_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [mlfq_pkg::IDX_W-1:0] idx,
  input  wire mlfq_pkg::mlfq_ctl_t       ctl,
  input  wire mlfq_pkg::mlfq_entry_t     left_i,
  input  wire mlfq_pkg::mlfq_entry_t     right_i,
  output mlfq_pkg::mlfq_entry_t          ent_o
);
  import mlfq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  mlfq_entry_t ent_r;
  mlfq_entry_t ent_nxt;
  logic        is_left;
  logic        is_right;
  logic [TIME_WIDTH-1:0] age;

  function automatic logic [LVL_W+IDX_W:0] sort_key(input mlfq_entry_t e);
    sort_key = {~e.valid, e.lvl, e.seq};
  endfunction

  assign is_left  = (idx[0] == ctl.phase) && (idx != LAST_IDX);
  assign is_right = (idx[0] != ctl.phase) && (idx != '0);
  assign age      = ctl.now - ent_r.stamp;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.op)
      OP_HOLD: begin
      end
      OP_WRITE: begin
        ent_nxt.seq = idx;
        if (idx == ctl.wr_idx) begin
          ent_nxt = ctl.wr_ent;
        end
      end
      OP_BOOST: begin
        if (ent_r.valid) begin
          ent_nxt.lvl   = '0;
          ent_nxt.stamp = ctl.now;
        end
      end
      OP_AGE: begin
        ent_nxt.seq = idx;
        if (ent_r.valid && (ent_r.lvl != '0) && (age >= ctl.thr)) begin
          ent_nxt.lvl   = ent_r.lvl - LVL_W'(1);
          ent_nxt.stamp = ctl.now;
        end
      end
      OP_SORT: begin
        if (is_left) begin
          if (sort_key(ent_r) > sort_key(right_i)) begin
            ent_nxt = right_i;
          end
        end else if (is_right) begin
          if (sort_key(left_i) > sort_key(ent_r)) begin
            ent_nxt = left_i;
          end
        end
      end
      OP_SHIFT: begin
        ent_nxt = right_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;

endmodule
`default_nettype wire
